// ===== design/psba_pkg.sv =====
// Shared types, codes and constants of the page slot bitmap allocator.
package psba_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned MAX_SLOTS      = 4095;
  localparam int unsigned MAX_WORDS      = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned REC_BYTES_RST  = 8;
  // divisor len*8+1 for a 12-bit length
  localparam int unsigned DIVISOR_W      = 15;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_CHECK  = 3'd2,
    REQ_FIRST  = 3'd3,
    REQ_NEXT   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NONE  = 2'd3
  } stat_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_out;
    logic        occupied;
    logic [11:0] data_offset;
    logic [11:0] slot_capacity;
  } rsp_t;

  typedef logic [11:0] cfg_t;

  // capacity unit status toward the control logic
  typedef struct packed {
    logic        busy;
    logic [11:0] cap;
  } div_sts_t;

endpackage

// ===== design/psba_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
interface psba_req_if ();
  logic            valid;
  logic            ready;
  psba_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psba_rsp_if ();
  logic            valid;
  logic            ready;
  psba_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psba_cfg_if ();
  logic            valid;
  logic            ready;
  psba_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/psba_cap_div.sv =====
// Bit-serial divider computing the slot capacity from the record length.
module psba_cap_div #(
  parameter int unsigned PAGE_BYTES = psba_pkg::PAGE_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [11:0]        len_i,
  output psba_pkg::div_sts_t sts_o
);

  localparam int unsigned NUM  = PAGE_BYTES * 8;
  localparam int unsigned NW   = $clog2(NUM + 1);
  localparam int unsigned CW   = $clog2(NW);
  localparam int unsigned DW   = psba_pkg::DIVISOR_W;
  localparam int unsigned QRST = NUM / (psba_pkg::REC_BYTES_RST * 8 + 1);
  localparam int unsigned CRST = (QRST > psba_pkg::MAX_SLOTS) ? psba_pkg::MAX_SLOTS : QRST;
  localparam logic [NW-1:0] DIVIDEND = NW'(NUM);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [11:0]   cap_q, cap_d;

  logic [DW:0]   sh;
  logic          ge;
  logic [DW:0]   diff;

  assign sh   = {rem_q, DIVIDEND[cnt_q]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cap_d  = cap_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW - 1);
      rem_d  = '0;
      dvs_d  = DW'({len_i, 3'b000}) + DW'(1);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        cap_d  = (32'(quo_d) > 32'(psba_pkg::MAX_SLOTS)) ? 12'(psba_pkg::MAX_SLOTS)
                                                         : 12'(quo_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      cap_q  <= 12'(CRST);
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      cap_q  <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.cap  = cap_q;

endmodule

// ===== design/psba_bitmap_mem.sv =====
// Occupancy word memory with registered read and per-word valid bits.
module psba_bitmap_mem #(
  parameter int unsigned WORDS = psba_pkg::MAX_WORDS,
  parameter int unsigned AW    = $clog2(psba_pkg::MAX_WORDS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [AW-1:0]                    rd_addr_i,
  output logic [psba_pkg::WORD_BITS-1:0]   rd_data_o,
  input  logic                             wr_en_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic [psba_pkg::WORD_BITS-1:0]   wr_data_i
);

  logic [psba_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]               vld_q;
  logic [psba_pkg::WORD_BITS-1:0] data_q;
  logic                           rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_q <= mem[rd_addr_i];
    end
  end

  // a word never written since reset reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? data_q : '0;

endmodule

// ===== design/page_slot_bitmap_allocator.sv =====
// Top level: request sequencer around the occupancy memory and capacity unit.
//
//  channel  dir  payload                                          word taken when
//  cfg_i    in   record length, 12 bits                           valid && ready
//  req_i    in   req_type, slot_index                             valid && ready
//  rsp_o    out  status, slot_out, occupied, data_offset, cap     valid && ready
//
// Insert, first and next scan the bitmap one memory word per cycle, then go through the
// offset stage to the response. In-range delete and check read a single word; requests
// answered without a read (out of range, unknown, nothing to scan) skip to the offset stage.
// After the response is loaded the sequencer returns to idle and takes the next request there.
// A record length write runs the serial divider; requests wait meanwhile, config is always
// taken.
// Reset empties the bitmap at once through per-word valid bits; no clearing pass.
// The response register lets the next request start while a response is stalled.
module page_slot_bitmap_allocator #(
  parameter int unsigned PAGE_BYTES = psba_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psba_cfg_if.sink    cfg_i,
  psba_req_if.sink    req_i,
  psba_rsp_if.source  rsp_o
);

  // a zero record length gives the largest capacity
  localparam int unsigned CAP_RAW = PAGE_BYTES * 8;
  localparam int unsigned MAX_CAP = (CAP_RAW > psba_pkg::MAX_SLOTS) ? psba_pkg::MAX_SLOTS
                                                                    : CAP_RAW;
  localparam int unsigned WORDS   = (MAX_CAP + psba_pkg::WORD_BITS - 1) / psba_pkg::WORD_BITS;
  localparam int unsigned WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [11:0] PAGE_LO = 12'(PAGE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EVAL = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  function automatic logic [5:0] enc64(input logic [63:0] oh);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (oh[i]) r = r | 6'(i);
    end
    return r;
  endfunction

  state_e              state_q, state_d;
  logic [2:0]          req_q, req_d;
  logic [11:0]         slot_q, slot_d;
  logic [WAW-1:0]      word_q, word_d;
  logic [5:0]          lo_q, lo_d;
  psba_pkg::stat_e     res_status_q, res_status_d;
  logic [11:0]         res_slot_q, res_slot_d;
  logic                res_occ_q, res_occ_d;
  logic                res_inr_q, res_inr_d;
  logic [11:0]         prod_q, prod_d;
  logic [11:0]         len_q, len_d;
  psba_pkg::rsp_t      out_q, out_d;
  logic                out_vld_q, out_vld_d;

  psba_pkg::div_sts_t  div_sts;
  logic [11:0]         cap;
  logic                cfg_acc, req_acc, out_free;

  logic                rd_en, wr_en;
  logic [WAW-1:0]      rd_addr;
  logic [63:0]         rd_word, wr_data;

  logic [5:0]          word_ext;
  logic [63:0]         hi_mask, lo_mask, cand, lsb;
  logic                found, more, bit_val;
  logic [12:0]         nxt_base, start13;
  logic [11:0]         cap_diff;
  logic [23:0]         prod_full;

  assign cap      = div_sts.cap;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE) && !div_sts.busy && !cfg_i.valid;

  psba_cap_div #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_acc),
    .len_i   (cfg_i.data),
    .sts_o   (div_sts)
  );

  psba_bitmap_mem #(
    .WORDS (WORDS),
    .AW    (WAW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (word_q),
    .wr_data_i (wr_data)
  );

  // bits of the current word that lie inside the page and at or after the start
  assign word_ext = 6'(word_q);
  assign hi_mask  = (word_ext < cap[11:6]) ? '1 :
                    (word_ext == cap[11:6]) ? ~({64{1'b1}} << cap[5:0]) : '0;
  assign lo_mask  = {64{1'b1}} << lo_q;
  assign cand     = ((req_q == psba_pkg::REQ_INSERT) ? ~rd_word : rd_word) & hi_mask & lo_mask;
  assign lsb      = cand & (~cand + 64'd1);
  assign found    = |cand;
  assign nxt_base = {7'(word_ext) + 7'd1, 6'd0};
  assign more     = nxt_base < {1'b0, cap};
  assign bit_val  = rd_word[slot_q[5:0]];
  assign start13  = (req_i.data.req_type == psba_pkg::REQ_FIRST) ? 13'd0
                                                                 : {1'b0, req_i.data.slot_index} + 13'd1;

  // next word is read ahead while the current one is evaluated
  assign rd_addr  = (state_q == S_RD) ? word_q : word_q + WAW'(1);
  assign rd_en    = (state_q == S_RD) ||
                    ((state_q == S_EVAL) && more && !found &&
                     (req_q == psba_pkg::REQ_INSERT || req_q == psba_pkg::REQ_FIRST ||
                      req_q == psba_pkg::REQ_NEXT));

  assign cap_diff  = cap - res_slot_q;
  assign prod_full = len_q * cap_diff;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    slot_d       = slot_q;
    word_d       = word_q;
    lo_d         = lo_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_occ_d    = res_occ_q;
    res_inr_d    = res_inr_q;
    prod_d       = prod_q;
    len_d        = len_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    wr_en        = 1'b0;
    wr_data      = rd_word;

    if (cfg_acc) len_d = cfg_i.data;
    if (out_vld_q && rsp_o.ready) out_vld_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          req_d        = req_i.data.req_type;
          slot_d       = req_i.data.slot_index;
          lo_d         = '0;
          res_occ_d    = 1'b0;
          res_inr_d    = 1'b0;
          res_slot_d   = req_i.data.slot_index;
          res_status_d = psba_pkg::STAT_EMPTY;
          state_d      = S_MUL;
          unique case (req_i.data.req_type)
            psba_pkg::REQ_INSERT: begin
              word_d = '0;
              if (cap == '0) begin
                res_status_d = psba_pkg::STAT_FULL;
                res_slot_d   = cap;
              end else begin
                state_d = S_RD;
              end
            end
            psba_pkg::REQ_DELETE, psba_pkg::REQ_CHECK: begin
              word_d = req_i.data.slot_index[6 +: WAW];
              if (req_i.data.slot_index < cap) state_d = S_RD;
            end
            psba_pkg::REQ_FIRST, psba_pkg::REQ_NEXT: begin
              word_d = start13[6 +: WAW];
              lo_d   = start13[5:0];
              if (start13 < {1'b0, cap}) begin
                state_d = S_RD;
              end else begin
                res_status_d = psba_pkg::STAT_NONE;
                res_slot_d   = cap;
              end
            end
            default: begin
              res_slot_d = '0;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d    = S_MUL;
        res_slot_d = slot_q;
        res_inr_d  = 1'b1;
        unique case (req_q)
          psba_pkg::REQ_INSERT, psba_pkg::REQ_FIRST, psba_pkg::REQ_NEXT: begin
            if (found) begin
              res_status_d = psba_pkg::STAT_OK;
              res_slot_d   = {word_ext, enc64(lsb)};
              res_occ_d    = 1'b1;
              if (req_q == psba_pkg::REQ_INSERT) begin
                wr_en   = 1'b1;
                wr_data = rd_word | lsb;
              end
            end else if (more) begin
              state_d = S_EVAL;
              word_d  = word_q + WAW'(1);
              lo_d    = '0;
            end else begin
              res_status_d = (req_q == psba_pkg::REQ_INSERT) ? psba_pkg::STAT_FULL
                                                             : psba_pkg::STAT_NONE;
              res_slot_d   = cap;
              res_occ_d    = 1'b0;
              res_inr_d    = 1'b0;
            end
          end
          psba_pkg::REQ_DELETE: begin
            res_occ_d = 1'b0;
            if (bit_val) begin
              res_status_d = psba_pkg::STAT_OK;
              wr_en        = 1'b1;
              wr_data      = rd_word & ~(64'd1 << slot_q[5:0]);
            end else begin
              res_status_d = psba_pkg::STAT_EMPTY;
            end
          end
          psba_pkg::REQ_CHECK: begin
            res_status_d = psba_pkg::STAT_OK;
            res_occ_d    = bit_val;
          end
          default: begin
            res_status_d = psba_pkg::STAT_EMPTY;
            res_slot_d   = '0;
            res_inr_d    = 1'b0;
          end
        endcase
      end
      S_MUL: begin
        prod_d  = prod_full[11:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d.status        = res_status_q;
          out_d.slot_out      = res_slot_q;
          out_d.occupied      = res_occ_q;
          out_d.data_offset   = res_inr_q ? (PAGE_LO - prod_q) : '0;
          out_d.slot_capacity = cap;
          out_vld_d           = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      len_q     <= 12'(psba_pkg::REC_BYTES_RST);
      req_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      len_q     <= len_d;
      req_q     <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    word_q       <= word_d;
    lo_q         <= lo_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_occ_q    <= res_occ_d;
    res_inr_q    <= res_inr_d;
    prod_q       <= prod_d;
    out_q        <= out_d;
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // memory is only written while a fetched word is being evaluated
  a_wr_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_EVAL)
    else $error("bitmap write outside word evaluation");

  // a write-back changes exactly one bit of the word
  a_wr_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ($countones(wr_data) == $countones(rd_word) + 1) ||
              ($countones(wr_data) + 1 == $countones(rd_word)))
    else $error("write-back does not change exactly one bit");

  // no request is taken while the capacity is being recomputed
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> !req_i.ready)
    else $error("request accepted during capacity update");

  // an accepted request either fetches a word or goes straight to the offset stage
  a_acc_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == S_RD) || (state_q == S_MUL))
    else $error("unexpected state after request accept");

  // an occupied slot reported must lie inside the page
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.occupied) |-> rsp_o.data.slot_out < rsp_o.data.slot_capacity)
    else $error("occupied slot beyond capacity");

endmodule

// ===== sim/psba_checker.sv =====
// Checker for the page slot allocator: tracks the occupancy map and compares each response.
`timescale 1ns / 100ps
module psba_checker #(
  parameter int unsigned PAGE_BYTES = psba_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psba_cfg_if         cfg_i,
  psba_req_if         req_i,
  psba_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  logic [4095:0]   occ_map  = '0;
  logic [11:0]     rec_len  = 12'(psba_pkg::REC_BYTES_RST);
  int unsigned     slot_cap = 0;
  int unsigned     fails    = 0;
  int unsigned     seen     = 0;
  psba_pkg::rsp_t  slot_results_q[$];

  function automatic int unsigned capacity_of(logic [11:0] len);
    int unsigned q;
    q = (PAGE_BYTES * 8) / (32'(len) * 8 + 1);
    return (q > psba_pkg::MAX_SLOTS) ? psba_pkg::MAX_SLOTS : q;
  endfunction

  // slots at or above the capacity never count, even if their bit is still set
  function automatic logic in_use(int unsigned s);
    return (s < slot_cap) && occ_map[s];
  endfunction

  function automatic psba_pkg::rsp_t page_response(psba_pkg::req_t r);
    psba_pkg::rsp_t  e;
    int unsigned     s;
    int unsigned     sout;
    int unsigned     i;
    logic            known;
    logic            hit;
    longint unsigned len64;
    longint unsigned off;
    s        = r.slot_index;
    sout     = 0;
    known    = 1'b1;
    hit      = 1'b0;
    e        = '0;
    e.status = psba_pkg::STAT_OK;
    case (r.req_type)
      psba_pkg::REQ_INSERT: begin
        sout     = slot_cap;
        e.status = psba_pkg::STAT_FULL;
        for (i = 0; i < slot_cap && !hit; i++) begin
          if (!in_use(i)) begin
            occ_map[i] = 1'b1;
            sout       = i;
            e.status   = psba_pkg::STAT_OK;
            hit        = 1'b1;
          end
        end
      end
      psba_pkg::REQ_DELETE: begin
        sout = s;
        if (in_use(s)) occ_map[s] = 1'b0;
        else e.status = psba_pkg::STAT_EMPTY;
      end
      psba_pkg::REQ_CHECK: begin
        sout     = s;
        e.status = (s < slot_cap) ? psba_pkg::STAT_OK : psba_pkg::STAT_EMPTY;
      end
      psba_pkg::REQ_FIRST, psba_pkg::REQ_NEXT: begin
        sout = slot_cap;
        for (i = (r.req_type == psba_pkg::REQ_FIRST) ? 0 : s + 1; i < slot_cap && !hit;
             i++) begin
          if (in_use(i)) begin
            sout = i;
            hit  = 1'b1;
          end
        end
        e.status = (sout < slot_cap) ? psba_pkg::STAT_OK : psba_pkg::STAT_NONE;
      end
      default: begin
        known    = 1'b0;
        e.status = psba_pkg::STAT_EMPTY;
      end
    endcase
    e.slot_out      = 12'(sout);
    e.occupied      = known && in_use(sout);
    e.slot_capacity = 12'(slot_cap);
    if (known && sout < slot_cap) begin
      len64         = rec_len;
      off           = PAGE_BYTES - len64 * slot_cap + len64 * sout;
      e.data_offset = off[11:0];
    end
    return e;
  endfunction

  task automatic compare_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t psba_chk: %s expected %0d got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_response(psba_pkg::rsp_t got);
    psba_pkg::rsp_t want;
    if (slot_results_q.size() == 0) begin
      $display("%0t psba_chk: response word with none expected, expected none got %h",
               $time, got);
      fails++;
    end else begin
      want = slot_results_q.pop_front();
      seen++;
      compare_field("status", 12'(want.status), 12'(got.status));
      compare_field("slot_out", want.slot_out, got.slot_out);
      compare_field("occupied", 12'(want.occupied), 12'(got.occupied));
      compare_field("data_offset", want.data_offset, got.data_offset);
      compare_field("slot_capacity", want.slot_capacity, got.slot_capacity);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_map  = '0;
      rec_len  = 12'(psba_pkg::REC_BYTES_RST);
      slot_cap = capacity_of(rec_len);
      slot_results_q.delete();
      fail_count_o <= fails;
      pending_o    <= 0;
      checked_o    <= seen;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        rec_len  = cfg_i.data;
        slot_cap = capacity_of(rec_len);
      end
      if (req_i.valid && req_i.ready) slot_results_q.push_back(page_response(req_i.data));
      if (rsp_i.valid && rsp_i.ready) check_response(rsp_i.data);
      fail_count_o <= fails;
      pending_o    <= slot_results_q.size();
      checked_o    <= seen;
    end
  end

endmodule

// ===== sim/tb_page_slot_bitmap_allocator.sv =====
// Testbench top: drives requests and record lengths into the allocator and reports the verdict.
`timescale 1ns / 100ps
module tb_page_slot_bitmap_allocator;

  localparam logic [2:0]  REQ_BAD_MIN = 3'd5;
  localparam logic [2:0]  REQ_BAD_MID = 3'd6;
  localparam logic [2:0]  REQ_BAD_MAX = 3'd7;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned NUM_FIXED   = 12;
  // lengths for the random phases; the last phases pick one at random
  localparam logic [11:0] FIXED_LENS [NUM_FIXED] = '{
    12'd1, 12'd4095, 12'd0, 12'd2047, 12'd64, 12'd511,
    12'd8, 12'd3, 12'd1000, 12'd4094, 12'd255, 12'd2
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psba_cfg_if cfg_if ();
  psba_req_if req_if ();
  psba_rsp_if rsp_if ();

  logic            req_valid_q = 1'b0;
  psba_pkg::req_t  req_word_q  = '0;
  logic            cfg_valid_q = 1'b0;
  psba_pkg::cfg_t  cfg_word_q  = '0;
  logic            rsp_ready_q = 1'b0;

  assign req_if.valid = req_valid_q;
  assign req_if.data  = req_word_q;
  assign cfg_if.valid = cfg_valid_q;
  assign cfg_if.data  = cfg_word_q;
  assign rsp_if.ready = rsp_ready_q;

  int unsigned send_idle_pct  = 20;
  int unsigned recv_stall_pct = 78;
  int unsigned fill_est       = 0;
  int unsigned n_reqs         = 0;
  int unsigned n_lens         = 0;
  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned chk_checked;

  page_slot_bitmap_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  psba_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending),
    .checked_o    (chk_checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_ready_q <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up after a word is taken so back-to-back words need no second write
  task automatic send_request(logic [2:0] kind, logic [11:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_q <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_q <= 1'b1;
    req_word_q  <= '{req_type: kind, slot_index: slot};
    do @(posedge clk_i); while (!req_if.ready);
    n_reqs++;
  endtask

  task automatic stop_requests();
    req_valid_q <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i); while (chk_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_record_len(logic [11:0] len);
    cfg_valid_q <= 1'b1;
    cfg_word_q  <= len;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid_q <= 1'b0;
    n_lens++;
  endtask

  task automatic random_request();
    logic [2:0]  kind;
    logic [11:0] slot;
    int unsigned p;
    int unsigned m;
    p = $urandom_range(99);
    if (p < 35) kind = psba_pkg::REQ_INSERT;
    else if (p < 55) kind = psba_pkg::REQ_DELETE;
    else if (p < 68) kind = psba_pkg::REQ_CHECK;
    else if (p < 76) kind = psba_pkg::REQ_FIRST;
    else if (p < 94) kind = psba_pkg::REQ_NEXT;
    else kind = 3'($urandom_range(REQ_BAD_MAX, REQ_BAD_MIN));
    // allocation is lowest-first, so slots near the fill level are mostly in use
    m = $urandom_range(9);
    if (m == 0) slot = 12'($urandom);
    else if (m < 4) slot = 12'($urandom_range(7));
    else slot = 12'($urandom_range(fill_est + 2));
    if (kind == psba_pkg::REQ_INSERT && fill_est < 4093) fill_est++;
    else if (kind == psba_pkg::REQ_DELETE && fill_est > 0) fill_est--;
    send_request(kind, slot);
  endtask

  initial begin
    logic [11:0] len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length: empty page, searches past the end, fill and reuse of a hole
    send_request(psba_pkg::REQ_FIRST, 12'd0);
    send_request(psba_pkg::REQ_NEXT, 12'd4095);
    send_request(psba_pkg::REQ_CHECK, 12'd0);
    send_request(psba_pkg::REQ_DELETE, 12'd0);
    send_request(psba_pkg::REQ_DELETE, 12'd4095);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_DELETE, 12'd1);
    send_request(psba_pkg::REQ_NEXT, 12'd0);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_CHECK, 12'd503);
    send_request(psba_pkg::REQ_CHECK, 12'd504);
    send_request(psba_pkg::REQ_NEXT, 12'd503);
    send_request(REQ_BAD_MIN, 12'hfff);
    send_request(REQ_BAD_MAX, 12'd0);
    stop_requests();
    settle();

    // single-slot page: full at once, old bits above the capacity ignored
    set_record_len(12'd4095);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_DELETE, 12'd0);
    send_request(psba_pkg::REQ_INSERT, 12'd0);
    send_request(psba_pkg::REQ_FIRST, 12'd0);
    send_request(psba_pkg::REQ_NEXT, 12'd0);
    send_request(psba_pkg::REQ_CHECK, 12'd2);
    stop_requests();
    settle();

    // capacity grows back and the kept bits count again
    set_record_len(12'd8);
    send_request(psba_pkg::REQ_NEXT, 12'd0);
    send_request(psba_pkg::REQ_DELETE, 12'd2);
    send_request(REQ_BAD_MID, 12'd2);
    stop_requests();
    settle();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph == 5) begin
        send_idle_pct  = 78;
        recv_stall_pct = 20;
      end else if (ph == 10) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      len = (ph < NUM_FIXED) ? FIXED_LENS[ph] : 12'($urandom_range(4095));
      set_record_len(len);
      fill_est = 0;
      repeat (PHASE_ITEMS) random_request();
      stop_requests();
      settle();
    end

    repeat (80) @(posedge clk_i);
    $display("tb: %0d requests sent under %0d record length writes, %0d responses compared",
             n_reqs, n_lens, chk_checked);
    $display("tb: idle mix went slow receiver, slow sender, then full rate");
    if (chk_fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== page_slot_bitmap_allocator.f =====
design/psba_pkg.sv
design/psba_if.sv
design/psba_cap_div.sv
design/psba_bitmap_mem.sv
design/page_slot_bitmap_allocator.sv
sim/psba_checker.sv
sim/tb_page_slot_bitmap_allocator.sv
